>>> rtl/core/dte_pkg.sv
// Shared types, constants and helper functions for direction_to_euler_angles.
// Used by dte_sqrt, dte_atan2 and the top level; depends on nothing else.
package dte_pkg;

  // Fixed-point formats
  localparam int DTE_POS_FRAC_BITS   = 16;
  localparam int DTE_ANGLE_FRAC_BITS = 13;
  localparam int DTE_ROUND_SH        = 32 - DTE_ANGLE_FRAC_BITS;

  // Pipeline depths
  localparam int DTE_CORDIC_ITERS = 32;
  localparam int DTE_SQRT_LAT     = 32;
  localparam int DTE_ATAN_LAT     = DTE_CORDIC_ITERS + 3;

  // Degenerate chord: all magnitudes below 2^14 and |c|^2 * 1e8 < 2^(2*frac)
  localparam int DTE_DEGEN_MAG_BITS = 14;
  localparam logic [63:0] DTE_DEGEN_SQ_MAX =
    ((64'd1 << (2 * DTE_POS_FRAC_BITS)) - 64'd1) / 64'd100000000;

  // Gimbal test divisor (1e-6 squared, inverted)
  localparam logic [39:0] DTE_GIMBAL_DIV = 40'd999999999999;

  // Angles in Q32 radians
  localparam logic signed [35:0] DTE_PI_Q32      = 36'sd13493037705;
  localparam logic signed [35:0] DTE_HALF_PI_Q32 = 36'sd6746518852;
  localparam logic signed [15:0] DTE_ROLL_PI =
    16'((64'(DTE_PI_Q32) + (64'd1 << (DTE_ROUND_SH - 1))) >> DTE_ROUND_SH);

  // atan(2^-i) in Q32, rounded to nearest
  localparam logic [31:0] DTE_ATAN_TAB [DTE_CORDIC_ITERS] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
    32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
    32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
    32'd1048576,    32'd524288,     32'd262144,     32'd131072,
    32'd65536,      32'd32768,      32'd16384,      32'd8192,
    32'd4096,       32'd2048,       32'd1024,       32'd512,
    32'd256,        32'd128,        32'd64,         32'd32,
    32'd16,         32'd8,          32'd4,          32'd2
  };

  // Configuration register index
  typedef enum logic [1:0] {
    DTE_REG_AP_X = 2'd0,
    DTE_REG_AP_Y = 2'd1,
    DTE_REG_AP_Z = 2'd2
  } dte_reg_t;

  // atan2 operand
  typedef logic signed [32:0] dte_op_t;

  // Sideband carried alongside the square root
  typedef struct packed {
    logic               degen;
    logic               helper;
    logic               roll_pi;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
  } dte_side_t;

  // Sideband carried alongside the atan2 units
  typedef struct packed {
    logic degen;
    logic helper;
    logic roll_pi;
  } dte_tag_t;

  // Position of the highest set bit, zero for a zero word
  function automatic logic [5:0] dte_msb(input logic [32:0] v);
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < 33; i++) begin
      if (v[i]) pos = 6'(i);
    end
    return pos;
  endfunction

endpackage

>>> rtl/core/dte_sqrt.sv
// Pipelined floor square root of a 63-bit radicand, one root bit per stage.
// Depends on dte_pkg for the stage count and the sideband type.
module dte_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [62:0]        rad,
  input  dte_pkg::dte_side_t side_in,
  output logic               out_vld,
  output logic [31:0]        root,
  output dte_pkg::dte_side_t side_out
);

  localparam int N = dte_pkg::DTE_SQRT_LAT;

  logic [34:0]        rem_r  [N];
  logic [31:0]        root_r [N];
  logic [63:0]        rad_r  [N];
  dte_pkg::dte_side_t side_r [N];
  logic [N-1:0]       vld_r;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [34:0] rem_i;
    logic [31:0] root_i;
    logic [63:0] rad_i;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;
    logic [34:0] rem_nxt;
    logic [31:0] root_nxt;
    logic [63:0] rad_nxt;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = {1'b0, rad};
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign rad_i  = rad_r[k-1];
    end

    // Bring down two radicand bits and try the next root bit
    always_comb begin
      rem_sh   = {rem_i[32:0], rad_i[63:62]};
      trial    = {1'b0, root_i, 2'b01};
      ge       = rem_sh >= trial;
      rem_nxt  = ge ? rem_sh - trial : rem_sh;
      root_nxt = {root_i[30:0], ge};
      rad_nxt  = {rad_i[61:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        rad_r[k]  <= rad_nxt;
        side_r[k] <= (k == 0) ? side_in : side_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], in_vld};
    end
  end

  assign out_vld  = vld_r[N-1];
  assign root     = root_r[N-1];
  assign side_out = side_r[N-1];

endmodule

>>> rtl/core/dte_atan2.sv
// Pipelined atan2 by vectoring CORDIC: normalize, 32 rotations, quadrant fix, round.
// Depends on dte_pkg for the angle table, constants and the operand type.
module dte_atan2 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  dte_pkg::dte_op_t   y,
  input  dte_pkg::dte_op_t   x,
  output logic               out_vld,
  output logic signed [15:0] angle
);

  localparam int N = dte_pkg::DTE_CORDIC_ITERS;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic zero;
  } quad_t;

  logic [32:0] ax_nxt, ay_nxt, mx_nxt;
  logic [31:0] n1_ax_r, n1_ay_r;
  logic [5:0]  n1_pos_r;
  quad_t       n1_q_r;
  logic        n1_vld_r;

  logic signed [33:0] vx_r [N+1];
  logic signed [33:0] vy_r [N+1];
  logic signed [35:0] z_r  [N+1];
  quad_t              q_r  [N+1];
  logic [N:0]         vld_r;

  logic [31:0] sx_nxt, sy_nxt;

  logic signed [35:0] zc, a;
  logic [35:0]        m, r;
  logic signed [15:0] angle_nxt;
  logic signed [15:0] angle_r;
  logic               out_vld_r;

  // Take magnitudes and find the leading bit of the larger one
  always_comb begin
    ax_nxt = x[32] ? 33'(-x) : 33'(x);
    ay_nxt = y[32] ? 33'(-y) : 33'(y);
    mx_nxt = (ax_nxt > ay_nxt) ? ax_nxt : ay_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_ax_r     <= ax_nxt[31:0];
      n1_ay_r     <= ay_nxt[31:0];
      n1_pos_r    <= dte_pkg::dte_msb(mx_nxt);
      n1_q_r.xneg <= x[32];
      n1_q_r.yneg <= y[32];
      n1_q_r.zero <= (mx_nxt == '0);
    end
  end

  // Shift both so the larger magnitude lies in [2^29, 2^30)
  always_comb begin
    if (n1_pos_r > 6'd29) begin
      sx_nxt = n1_ax_r >> (n1_pos_r - 6'd29);
      sy_nxt = n1_ay_r >> (n1_pos_r - 6'd29);
    end else begin
      sx_nxt = n1_ax_r << (6'd29 - n1_pos_r);
      sy_nxt = n1_ay_r << (6'd29 - n1_pos_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx_r[0] <= $signed({4'b0, sx_nxt[29:0]});
      vy_r[0] <= $signed({4'b0, sy_nxt[29:0]});
      z_r[0]  <= '0;
      q_r[0]  <= n1_q_r;
    end
  end

  // Rotation stages: drive vy toward zero, accumulate the angle
  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [33:0] dx, dy;
    logic signed [35:0] step;

    always_comb begin
      dx   = vy_r[i] >>> i;
      dy   = vx_r[i] >>> i;
      step = $signed({4'b0, dte_pkg::DTE_ATAN_TAB[i]});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!vy_r[i][33]) begin
          vx_r[i+1] <= vx_r[i] + dx;
          vy_r[i+1] <= vy_r[i] - dy;
          z_r[i+1]  <= z_r[i] + step;
        end else begin
          vx_r[i+1] <= vx_r[i] - dx;
          vy_r[i+1] <= vy_r[i] + dy;
          z_r[i+1]  <= z_r[i] - step;
        end
        q_r[i+1] <= q_r[i];
      end
    end
  end

  // Clamp to the first quadrant, mirror, round half away from zero
  always_comb begin
    if (z_r[N] < 0) begin
      zc = '0;
    end else if (z_r[N] > dte_pkg::DTE_HALF_PI_Q32) begin
      zc = dte_pkg::DTE_HALF_PI_Q32;
    end else begin
      zc = z_r[N];
    end
    a = q_r[N].xneg ? dte_pkg::DTE_PI_Q32 - zc : zc;
    m = 36'(a);
    r = (m + (36'd1 << (dte_pkg::DTE_ROUND_SH - 1))) >> dte_pkg::DTE_ROUND_SH;
    if (q_r[N].zero) begin
      angle_nxt = '0;
    end else if (q_r[N].yneg) begin
      angle_nxt = -$signed(r[15:0]);
    end else begin
      angle_nxt = $signed(r[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_vld_r  <= 1'b0;
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      n1_vld_r  <= in_vld;
      vld_r     <= {vld_r[N-1:0], n1_vld_r};
      out_vld_r <= vld_r[N];
    end
  end

  assign out_vld = out_vld_r;
  assign angle   = angle_r;

endmodule

>>> rtl/core/direction_to_euler_angles.sv
// Top level: aiming angles (ZYX roll, pitch, yaw) of the ray from an aperture to a hit.
// Depends on dte_pkg, dte_sqrt and dte_atan2.
//
// Usage:
//   Input stream in_*: one hit point per request, tdata = hit_x, hit_y, hit_z
//   (Q15.16 metres). Output stream out_*: tdata = roll, pitch, yaw (Q2.13 rad),
//   tuser = degenerate flag (chord under 0.1 mm, angles then zero).
//   Config port cfg_*: index 0..2 writes aperture x, y, z; always ready.
//   Write the aperture only while the pipeline holds no request.
// Timing:
//   The pipeline has 4 chord/normalize stages, 32 square-root stages,
//   35 atan2 stages (normalize, 32 CORDIC rotations, round) and the output
//   register. A new request is accepted every cycle unless the output stalls.
// Reset:
//   rst_n clears all valid bits and the aperture registers to zero.
// Backpressure:
//   When out_tready is low with a result waiting, the whole pipeline holds
//   and in_tready drops in the same cycle; nothing is lost or repeated.
module direction_to_euler_angles (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: hit_x [31:0], hit_y [63:32], hit_z [95:64]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,
  // out_tdata: roll_angle [15:0], pitch_angle [31:16], yaw_angle [47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  // out_tuser: degenerate [0]
  output logic [0:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int TAG_N = dte_pkg::DTE_ATAN_LAT;

  logic en;

  logic [31:0] ap_x_r, ap_y_r, ap_z_r;

  // Stage 1
  logic signed [32:0] t1_cx_r, t1_cy_r, t1_cz_r;
  logic               t1_vld_r;
  // Stage 2
  logic [32:0] mx_nxt, my_nxt, mz_nxt, top_nxt;
  logic [32:0] t2_mx_r, t2_my_r, t2_mz_r;
  logic        t2_xneg_r, t2_yneg_r, t2_zneg_r;
  logic [5:0]  t2_pos_r;
  logic        t2_vld_r;
  // Stage 3
  logic [5:0]  lsh_nxt;
  logic [32:0] nx_nxt, ny_nxt, nz_nxt;
  logic [64:0] t3_mx2_r, t3_my2_r, t3_mz2_r;
  logic [30:0] t3_nx_r, t3_ny_r, t3_nz_r;
  logic        t3_xneg_r, t3_yneg_r, t3_zneg_r, t3_zzero_r;
  logic        t3_vld_r;
  // Stage 4
  logic [73:0] hlp_lhs, hlp_sum, hlp_rhs;
  logic [65:0] gim_prod;
  logic        gimbal_nxt, small_nxt;
  logic [29:0] sq_small;
  logic        t4_degen_r, t4_helper_r, t4_roll_pi_r;
  logic [61:0] t4_nx2_r, t4_ny2_r, t4_nz2_r;
  logic signed [31:0] t4_sx_r, t4_sy_r, t4_sz_r;
  logic        t4_vld_r;

  logic [62:0]        rad_nxt;
  dte_pkg::dte_side_t side_nxt;
  logic               sq_vld;
  logic [31:0]        sq_root;
  dte_pkg::dte_side_t sq_side;

  dte_pkg::dte_op_t   a_y, a_x, b_y, b_x, k_op;
  logic               a_vld, b_vld;
  logic signed [15:0] a_ang, b_ang;
  dte_pkg::dte_tag_t  tag_r [TAG_N];

  logic signed [15:0] roll_nxt, pitch_nxt, yaw_nxt;
  logic               out_vld_r;
  logic [47:0]        out_data_r;
  logic               out_degen_r;

  // Whole pipeline advances unless a result is stuck at the output
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ap_x_r <= '0;
      ap_y_r <= '0;
      ap_z_r <= '0;
    end else if (cfg_valid) begin
      case (dte_pkg::dte_reg_t'(cfg_index))
        dte_pkg::DTE_REG_AP_X: ap_x_r <= cfg_data;
        dte_pkg::DTE_REG_AP_Y: ap_y_r <= cfg_data;
        dte_pkg::DTE_REG_AP_Z: ap_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: chord from the aperture
  always_ff @(posedge clk) begin
    if (en) begin
      t1_cx_r <= $signed({in_tdata[31], in_tdata[31:0]}) - $signed({ap_x_r[31], ap_x_r});
      t1_cy_r <= $signed({in_tdata[63], in_tdata[63:32]}) - $signed({ap_y_r[31], ap_y_r});
      t1_cz_r <= $signed({in_tdata[95], in_tdata[95:64]}) - $signed({ap_z_r[31], ap_z_r});
    end
  end

  // Stage 2: magnitudes and leading bit of the largest
  always_comb begin
    mx_nxt  = t1_cx_r[32] ? 33'(-t1_cx_r) : 33'(t1_cx_r);
    my_nxt  = t1_cy_r[32] ? 33'(-t1_cy_r) : 33'(t1_cy_r);
    mz_nxt  = t1_cz_r[32] ? 33'(-t1_cz_r) : 33'(t1_cz_r);
    top_nxt = (mx_nxt > my_nxt) ? mx_nxt : my_nxt;
    if (mz_nxt > top_nxt) top_nxt = mz_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_mx_r   <= mx_nxt;
      t2_my_r   <= my_nxt;
      t2_mz_r   <= mz_nxt;
      t2_xneg_r <= t1_cx_r[32];
      t2_yneg_r <= t1_cy_r[32];
      t2_zneg_r <= t1_cz_r[32];
      t2_pos_r  <= dte_pkg::dte_msb(top_nxt);
    end
  end

  // Stage 3: squares of the chord, group normalization
  always_comb begin
    lsh_nxt = 6'd30 - t2_pos_r;
    if (t2_pos_r >= 6'd31) begin
      nx_nxt = t2_mx_r >> 1;
      ny_nxt = t2_my_r >> 1;
      nz_nxt = t2_mz_r >> 1;
    end else begin
      nx_nxt = t2_mx_r << lsh_nxt;
      ny_nxt = t2_my_r << lsh_nxt;
      nz_nxt = t2_mz_r << lsh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3_mx2_r   <= 65'(66'(t2_mx_r) * 66'(t2_mx_r));
      t3_my2_r   <= 65'(66'(t2_my_r) * 66'(t2_my_r));
      t3_mz2_r   <= 65'(66'(t2_mz_r) * 66'(t2_mz_r));
      t3_nx_r    <= nx_nxt[30:0];
      t3_ny_r    <= ny_nxt[30:0];
      t3_nz_r    <= nz_nxt[30:0];
      t3_xneg_r  <= t2_xneg_r;
      t3_yneg_r  <= t2_yneg_r;
      t3_zneg_r  <= t2_zneg_r;
      t3_zzero_r <= (t2_mz_r == '0);
    end
  end

  // Stage 4: degenerate, helper axis and gimbal decisions; normalized squares
  always_comb begin
    hlp_lhs = (74'(t3_mx2_r) << 4) + (74'(t3_mx2_r) << 1) + 74'(t3_mx2_r);
    hlp_sum = 74'(t3_my2_r) + 74'(t3_mz2_r);
    hlp_rhs = (hlp_sum << 6) + (hlp_sum << 4) + hlp_sum;
    gim_prod = 66'(t3_mz2_r[24:0]) * 66'(dte_pkg::DTE_GIMBAL_DIV);
    gimbal_nxt = t3_zzero_r ||
                 ((t3_mz2_r < (65'd1 << 25)) && (gim_prod <= 66'(t3_my2_r)));
    small_nxt = (t3_mx2_r < (65'd1 << (2 * dte_pkg::DTE_DEGEN_MAG_BITS))) &&
                (t3_my2_r < (65'd1 << (2 * dte_pkg::DTE_DEGEN_MAG_BITS))) &&
                (t3_mz2_r < (65'd1 << (2 * dte_pkg::DTE_DEGEN_MAG_BITS)));
    sq_small = 30'(t3_mx2_r[27:0]) + 30'(t3_my2_r[27:0]) + 30'(t3_mz2_r[27:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t4_degen_r   <= small_nxt && (64'(sq_small) <= dte_pkg::DTE_DEGEN_SQ_MAX);
      t4_helper_r  <= hlp_lhs > hlp_rhs;
      t4_roll_pi_r <= t3_zneg_r && !gimbal_nxt;
      t4_nx2_r     <= 62'(t3_nx_r) * 62'(t3_nx_r);
      t4_ny2_r     <= 62'(t3_ny_r) * 62'(t3_ny_r);
      t4_nz2_r     <= 62'(t3_nz_r) * 62'(t3_nz_r);
      t4_sx_r      <= t3_xneg_r ? -$signed({1'b0, t3_nx_r}) : $signed({1'b0, t3_nx_r});
      t4_sy_r      <= t3_yneg_r ? -$signed({1'b0, t3_ny_r}) : $signed({1'b0, t3_ny_r});
      t4_sz_r      <= t3_zneg_r ? -$signed({1'b0, t3_nz_r}) : $signed({1'b0, t3_nz_r});
    end
  end

  // Pick the hypotenuse for the active helper axis
  always_comb begin
    rad_nxt = t4_helper_r ? 63'(t4_nx2_r) + 63'(t4_ny2_r)
                          : 63'(t4_ny2_r) + 63'(t4_nz2_r);
    side_nxt.degen   = t4_degen_r;
    side_nxt.helper  = t4_helper_r;
    side_nxt.roll_pi = t4_roll_pi_r;
    side_nxt.sx      = t4_sx_r;
    side_nxt.sy      = t4_sy_r;
    side_nxt.sz      = t4_sz_r;
  end

  dte_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (t4_vld_r),
    .rad      (rad_nxt),
    .side_in  (side_nxt),
    .out_vld  (sq_vld),
    .root     (sq_root),
    .side_out (sq_side)
  );

  // Operands of the two atan2 units
  always_comb begin
    k_op = $signed({1'b0, sq_root});
    if (sq_side.helper) begin
      a_y = k_op;
      a_x = 33'(sq_side.sz);
    end else if (sq_side.roll_pi) begin
      a_y = -33'(sq_side.sx);
      a_x = -k_op;
    end else begin
      a_y = 33'(sq_side.sx);
      a_x = k_op;
    end
    b_y = -33'(sq_side.sy);
    if (sq_side.helper) begin
      b_x = 33'(sq_side.sx);
    end else begin
      b_x = sq_side.sz[31] ? -33'(sq_side.sz) : 33'(sq_side.sz);
    end
  end

  dte_atan2 u_atan_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sq_vld),
    .y       (a_y),
    .x       (a_x),
    .out_vld (a_vld),
    .angle   (a_ang)
  );

  dte_atan2 u_atan_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sq_vld),
    .y       (b_y),
    .x       (b_x),
    .out_vld (b_vld),
    .angle   (b_ang)
  );

  // Delay the branch flags alongside the atan2 units
  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0].degen   <= sq_side.degen;
      tag_r[0].helper  <= sq_side.helper;
      tag_r[0].roll_pi <= sq_side.roll_pi;
      for (int i = 1; i < TAG_N; i++) begin
        tag_r[i] <= tag_r[i-1];
      end
    end
  end

  // Assemble the angles for the active branch
  always_comb begin
    if (tag_r[TAG_N-1].degen) begin
      roll_nxt  = '0;
      pitch_nxt = '0;
      yaw_nxt   = '0;
    end else if (tag_r[TAG_N-1].helper) begin
      roll_nxt  = b_ang;
      pitch_nxt = '0;
      yaw_nxt   = a_ang;
    end else begin
      roll_nxt  = tag_r[TAG_N-1].roll_pi ? dte_pkg::DTE_ROLL_PI : '0;
      pitch_nxt = b_ang;
      yaw_nxt   = a_ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r  <= {yaw_nxt, pitch_nxt, roll_nxt};
      out_degen_r <= tag_r[TAG_N-1].degen;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r  <= 1'b0;
      t2_vld_r  <= 1'b0;
      t3_vld_r  <= 1'b0;
      t4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      t1_vld_r  <= in_tvalid;
      t2_vld_r  <= t1_vld_r;
      t3_vld_r  <= t2_vld_r;
      t4_vld_r  <= t3_vld_r;
      out_vld_r <= a_vld && b_vld;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_degen_r;

`ifndef NO_ASSERTIONS
  // Both atan2 units carry the same request
  a_atan_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld == b_vld)
    else $error("atan2 units out of step");

  // A degenerate result carries zero angles
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("degenerate result with nonzero angles");

  // Either pitch is zero (helper branch) or roll is zero or pi (no helper)
  a_branch_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |->
      (out_tdata[31:16] == '0) || (out_tdata[15:0] == '0) ||
      ($signed(out_tdata[15:0]) == dte_pkg::DTE_ROLL_PI))
    else $error("roll and pitch from different branches");
`endif

endmodule
